/* design/far_pkg.sv */
// Shared types and constants for the fraction reduce block.
// No dependencies.
package far_pkg;

    localparam logic [2:0] OP_REDUCE = 3'd0;
    localparam logic [2:0] OP_SUM    = 3'd1;
    localparam logic [2:0] OP_DIFF   = 3'd2;
    localparam logic [2:0] OP_PROD   = 3'd3;
    localparam logic [2:0] OP_QUOT   = 3'd4;

    typedef enum logic [1:0] {
        SEL_SUM  = 2'd0,
        SEL_DIFF = 2'd1,
        SEL_PROD = 2'd2,
        SEL_QUOT = 2'd3
    } sel_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input operands
        logic mul_a;      // first products
        logic mul_b;      // second products
        logic setup;      // pick numerator/denominator for sel
        sel_t sel;
        logic div_start;  // start one long division
        logic div_x;      // load gcd pair: x = |n|, y = d
        logic gcd_step;   // apply remainder to gcd pair
        logic quot_n;     // start n/g
        logic quot_d;     // start d/g
        logic out_load;   // write output register
        logic [2:0] op;
        logic last;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
        logic y_zero;
        logic zero_div;
    } status_t;

endpackage

/* design/fraction_arith_reduce.sv */
// Fraction arithmetic with gcd reduction, top level.
// Usage:
//   Input channel (in_valid/in_stall) carries command and the two fractions.
//   Command 0 yields one result: fraction a in lowest terms.
//   Command 1 yields four results: sum, difference, product, quotient;
//   last marks the final one. A zero divisor gives a 0/0 quotient with divide_error.
//   Output channel (out_valid/out_stall) carries one result per transfer.
// Timing:
//   One item at a time: a multiply phase (S_MUL_A, S_MUL_B), then each result runs
//   Euclid's gcd on a shared restoring divider plus two divisions by the gcd.
//   in_stall is high from acceptance until the last result is transferred; the
//   next item is taken the cycle after.
// Stalls: a result holds on the outputs while out_stall is high; work on
//   the next result waits for that transfer.
// Reset: rst_n asynchronous, active low; returns to idle, no result pending.
// Depends on far_pkg, far_ctrl, far_reduce_core, far_datapath.
module fraction_arith_reduce #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      command,
    input  logic signed [OPERAND_WIDTH-1:0] a_numerator,
    input  logic [OPERAND_WIDTH-2:0]  a_denominator,
    input  logic signed [OPERAND_WIDTH-1:0] b_numerator,
    input  logic [OPERAND_WIDTH-2:0]  b_denominator,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [2:0]                operation,
    output logic signed [31:0]        numerator,
    output logic [30:0]               denominator,
    output logic                      divide_error,
    output logic                      last
);
    import far_pkg::*;

    cmd_t    cmd;
    status_t status;

    far_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_stall, .command,
        .out_valid, .out_stall, .cmd, .status
    );

    far_reduce_core #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_core (
        .clk, .rst_n, .cmd, .status, .command,
        .a_numerator, .a_denominator, .b_numerator, .b_denominator,
        .operation, .numerator, .denominator, .divide_error, .last
    );

endmodule

/* design/far_datapath.sv */
// Datapath: operand registers, multiplier, shared restoring divider, output register.
// Depends on far_pkg.
module far_datapath #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  far_pkg::cmd_t             cmd,
    output far_pkg::status_t          status,
    input  logic signed [OPERAND_WIDTH-1:0] a_numerator,
    input  logic [OPERAND_WIDTH-2:0]  a_denominator,
    input  logic signed [OPERAND_WIDTH-1:0] b_numerator,
    input  logic [OPERAND_WIDTH-2:0]  b_denominator,
    output logic [2:0]                operation,
    output logic signed [31:0]        numerator,
    output logic [30:0]               denominator,
    output logic                      divide_error,
    output logic                      last
);
    import far_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int PW = 2 * W + 1;          // signed product/sum width
    localparam int MW = 2 * W;              // magnitude width
    localparam int CW = $clog2(MW + 1);

    logic signed [W-1:0] an_reg, bn_reg;
    logic signed [W:0]   ad_reg, bd_reg;
    logic signed [PW-1:0] p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [PW-1:0] n_reg;
    logic [MW-1:0] d_reg, x_reg, y_reg;
    logic [MW-1:0] dv_q_reg, dv_r_reg, dv_d_reg;
    logic [CW-1:0] dv_cnt_reg;
    logic          dv_busy_reg, dv_done_reg;

    logic signed [W:0]   m_x, m_y;
    logic signed [PW-1:0] m_p;
    logic [MW-1:0] dn_mag;
    logic [MW:0]   trial;

    assign m_x = cmd.mul_a ? {{1{an_reg[W-1]}}, an_reg} : ad_reg;
    assign m_y = cmd.mul_a ? bd_reg : {{1{bn_reg[W-1]}}, bn_reg};
    assign m_p = PW'(m_x) * PW'(m_y);
    assign dn_mag = n_reg[PW-1] ? MW'(-n_reg) : MW'(n_reg);
    assign trial = {dv_r_reg, dv_q_reg[MW-1]} - {1'b0, dv_d_reg};

    assign status.div_done = dv_done_reg;
    assign status.y_zero   = (y_reg == '0);
    assign status.zero_div = (bn_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_busy_reg <= 1'b0;
            dv_done_reg <= 1'b0;
            dv_cnt_reg  <= '0;
            dv_q_reg    <= '0;
            dv_r_reg    <= '0;
            dv_d_reg    <= '0;
        end
        else
        begin
            dv_done_reg <= 1'b0;
            if (cmd.div_start)
            begin
                dv_busy_reg <= 1'b1;
                dv_cnt_reg  <= CW'(MW);
                dv_r_reg    <= '0;
                if (cmd.quot_n)
                begin
                    dv_q_reg <= dn_mag;
                    dv_d_reg <= x_reg;
                end
                else if (cmd.quot_d)
                begin
                    dv_q_reg <= d_reg;
                    dv_d_reg <= x_reg;
                end
                else
                begin
                    dv_q_reg <= x_reg;
                    dv_d_reg <= y_reg;
                end
            end
            else if (dv_busy_reg)
            begin
                if (!trial[MW])
                begin
                    dv_r_reg <= trial[MW-1:0];
                    dv_q_reg <= {dv_q_reg[MW-2:0], 1'b1};
                end
                else
                begin
                    dv_r_reg <= {dv_r_reg[MW-2:0], dv_q_reg[MW-1]};
                    dv_q_reg <= {dv_q_reg[MW-2:0], 1'b0};
                end
                dv_cnt_reg <= dv_cnt_reg - 1'b1;
                if (dv_cnt_reg == CW'(1))
                begin
                    dv_busy_reg <= 1'b0;
                    dv_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            an_reg <= a_numerator;
            bn_reg <= b_numerator;
            ad_reg <= (a_denominator == '0) ? (W+1)'(1) : (W+1)'(a_denominator);
            bd_reg <= (b_denominator == '0) ? (W+1)'(1) : (W+1)'(b_denominator);
        end
        if (cmd.mul_a)
        begin
            p1_reg <= m_p;                              // an*bd
            p3_reg <= PW'(ad_reg) * PW'(bd_reg);        // ad*bd
        end
        if (cmd.mul_b)
        begin
            p2_reg <= m_p;                              // ad*bn
            p4_reg <= PW'(an_reg) * PW'(bn_reg);        // an*bn
        end
        if (cmd.setup)
        begin
            case (cmd.sel)
                SEL_SUM:
                begin
                    n_reg <= p1_reg + p2_reg;
                    d_reg <= MW'(p3_reg);
                end
                SEL_DIFF:
                begin
                    n_reg <= p1_reg - p2_reg;
                    d_reg <= MW'(p3_reg);
                end
                SEL_PROD:
                begin
                    n_reg <= p4_reg;
                    d_reg <= MW'(p3_reg);
                end
                default:
                begin
                    n_reg <= p2_reg[PW-1] ? -p1_reg : p1_reg;
                    d_reg <= p2_reg[PW-1] ? MW'(-p2_reg) : MW'(p2_reg);
                end
            endcase
            x_reg <= '0;
            y_reg <= '0;
        end
        if (cmd.div_x)
        begin
            // start gcd: x = |n|, y = d
            x_reg <= dn_mag;
            y_reg <= d_reg;
        end
        if (cmd.gcd_step)
        begin
            x_reg <= y_reg;
            y_reg <= dv_r_reg;
        end
        if (cmd.out_load)
        begin
            operation    <= cmd.op;
            divide_error <= 1'b0;
            last         <= cmd.last;
            if (cmd.sel == SEL_QUOT && bn_reg == '0 && cmd.op == OP_QUOT)
            begin
                numerator    <= '0;
                denominator  <= '0;
                divide_error <= 1'b1;
            end
            else
            begin
                numerator   <= 32'(n_reg);
                denominator <= 31'(d_reg);
            end
        end
        if (cmd.quot_n && dv_done_reg)
            n_reg <= n_reg[PW-1] ? -PW'(dv_q_reg) : PW'(dv_q_reg);
        if (cmd.quot_d && dv_done_reg)
            d_reg <= dv_q_reg;
    end

endmodule

/* design/far_ctrl.sv */
// Controller state machine sequencing multiply, gcd and divide steps.
// Depends on far_pkg.
module far_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              command,
    output logic              out_valid,
    input  logic              out_stall,
    output far_pkg::cmd_t     cmd,
    input  far_pkg::status_t  status
);
    import far_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL_A, S_MUL_B, S_SETUP, S_GCD_INIT, S_GCD_TEST, S_GCD_WAIT,
        S_QN_WAIT, S_QD_START, S_QD_WAIT, S_OUT, S_HOLD
    } state_t;

    state_t state_reg;
    sel_t   sel_reg;
    logic   pair_reg, out_valid_reg;
    logic [2:0] op;
    logic   lst;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign op  = !pair_reg ? OP_REDUCE : (3'(sel_reg) + 3'd1);
    assign lst = !pair_reg || (sel_reg == SEL_QUOT);

    always_comb
    begin
        cmd = '0;
        cmd.sel = sel_reg;
        cmd.op = op;
        cmd.last = lst;
        case (state_reg)
            S_IDLE:     cmd.load = in_valid;
            S_MUL_A:    cmd.mul_a = 1'b1;
            S_MUL_B:    cmd.mul_b = 1'b1;
            S_SETUP:    cmd.setup = 1'b1;
            S_GCD_INIT: cmd.div_x = 1'b1;
            S_GCD_TEST: cmd.div_start = !status.y_zero;
            S_GCD_WAIT: cmd.gcd_step = status.div_done;
            S_QN_WAIT:
            begin
                cmd.quot_n = 1'b1;
            end
            S_QD_START:
            begin
                cmd.quot_d = 1'b1;
                cmd.div_start = 1'b1;
            end
            S_QD_WAIT:  cmd.quot_d = 1'b1;
            S_OUT:      cmd.out_load = 1'b1;
            default:    ;
        endcase
        if (state_reg == S_GCD_TEST && status.y_zero)
        begin
            // x holds gcd; start n/g
            cmd.quot_n = 1'b1;
            cmd.div_start = (status.y_zero);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sel_reg       <= SEL_SUM;
            pair_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        pair_reg  <= command;
                        // reduce-only takes the product path with b = 1/1
                        sel_reg   <= command ? SEL_SUM : SEL_PROD;
                        state_reg <= S_MUL_A;
                    end
                end
                S_MUL_A: state_reg <= S_MUL_B;
                S_MUL_B: state_reg <= S_SETUP;
                S_SETUP:
                begin
                    if (sel_reg == SEL_QUOT && status.zero_div)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_GCD_INIT;
                end
                S_GCD_INIT: state_reg <= S_GCD_TEST;
                S_GCD_TEST:
                begin
                    if (status.y_zero)
                        state_reg <= S_QN_WAIT;
                    else
                        state_reg <= S_GCD_WAIT;
                end
                S_GCD_WAIT:
                    if (status.div_done)
                        state_reg <= S_GCD_TEST;
                S_QN_WAIT:
                    if (status.div_done)
                        state_reg <= S_QD_START;
                S_QD_START: state_reg <= S_QD_WAIT;
                S_QD_WAIT:
                    if (status.div_done)
                        state_reg <= S_OUT;
                S_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_HOLD;
                end
                S_HOLD:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        if (!pair_reg || sel_reg == SEL_QUOT)
                            state_reg <= S_IDLE;
                        else
                        begin
                            sel_reg   <= sel_t'(sel_reg + 2'd1);
                            state_reg <= S_SETUP;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* design/far_reduce_core.sv */
// Reduce-only operand shaping: for command 0 the fraction a passes as a*1/1.
// Depends on far_pkg; wraps the datapath.
module far_reduce_core #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  far_pkg::cmd_t             cmd,
    output far_pkg::status_t          status,
    input  logic                      command,
    input  logic signed [OPERAND_WIDTH-1:0] a_numerator,
    input  logic [OPERAND_WIDTH-2:0]  a_denominator,
    input  logic signed [OPERAND_WIDTH-1:0] b_numerator,
    input  logic [OPERAND_WIDTH-2:0]  b_denominator,
    output logic [2:0]                operation,
    output logic signed [31:0]        numerator,
    output logic [30:0]               denominator,
    output logic                      divide_error,
    output logic                      last
);
    import far_pkg::*;

    logic signed [OPERAND_WIDTH-1:0] bn_in;
    logic [OPERAND_WIDTH-2:0] bd_in;

    // command 0: b = 1/1 so the product path gives an/ad
    assign bn_in = command ? b_numerator : OPERAND_WIDTH'(1);
    assign bd_in = command ? b_denominator : (OPERAND_WIDTH-1)'(1);

    far_datapath #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .clk, .rst_n, .cmd, .status,
        .a_numerator, .a_denominator,
        .b_numerator(bn_in), .b_denominator(bd_in),
        .operation, .numerator, .denominator, .divide_error, .last
    );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Testbench for fraction_arith_reduce: drives random and corner fractions,
// predicts reduced results in 64-bit integer math. Depends on far_pkg and the RTL.
module tb;
    import far_pkg::*;

    localparam int W = 16;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] num;
        logic [30:0] den;
        logic        derr;
        logic        lst;
    } frac_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic command;
    logic signed [W-1:0] a_numerator;
    logic [W-2:0] a_denominator;
    logic signed [W-1:0] b_numerator;
    logic [W-2:0] b_denominator;
    logic out_valid;
    logic out_stall;
    logic [2:0] operation;
    logic signed [31:0] numerator;
    logic [30:0] denominator;
    logic divide_error;
    logic last;

    frac_result_t pending_results[$];
    int mismatches;
    int results_seen;
    int items_sent;
    bit hold_receiver;
    int hold_cycles;

    fraction_arith_reduce #(.OPERAND_WIDTH(W)) u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command),
        .a_numerator(a_numerator), .a_denominator(a_denominator),
        .b_numerator(b_numerator), .b_denominator(b_denominator),
        .out_valid(out_valid), .out_stall(out_stall),
        .operation(operation), .numerator(numerator),
        .denominator(denominator), .divide_error(divide_error), .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
        longint unsigned r;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic frac_result_t reduce_frac(logic [2:0] op, longint n, longint d,
                                                 logic lst);
        frac_result_t res;
        longint unsigned g;
        g = gcd64((n < 0) ? longint'(-n) : n, d);
        if (g != 0)
        begin
            n = n / longint'(g);
            d = d / longint'(g);
        end
        res.op = op;
        res.num = n[31:0];
        res.den = d[30:0];
        res.derr = 1'b0;
        res.lst = lst;
        return res;
    endfunction

    task automatic predict_results(logic cmd, logic [W-1:0] an_f, logic [W-2:0] ad_f,
                                   logic [W-1:0] bn_f, logic [W-2:0] bd_f);
        longint an, ad, bn, bd, qn, qd;
        frac_result_t res;
        an = longint'($signed(an_f));
        bn = longint'($signed(bn_f));
        ad = (ad_f == 0) ? 1 : longint'(ad_f);
        bd = (bd_f == 0) ? 1 : longint'(bd_f);
        if (cmd == 1'b0)
        begin
            pending_results.push_back(reduce_frac(OP_REDUCE, an, ad, 1'b1));
        end
        else
        begin
            pending_results.push_back(reduce_frac(OP_SUM, an * bd + ad * bn, ad * bd, 1'b0));
            pending_results.push_back(reduce_frac(OP_DIFF, an * bd - ad * bn, ad * bd, 1'b0));
            pending_results.push_back(reduce_frac(OP_PROD, an * bn, ad * bd, 1'b0));
            if (bn == 0)
            begin
                res.op = OP_QUOT;
                res.num = '0;
                res.den = '0;
                res.derr = 1'b1;
                res.lst = 1'b1;
                pending_results.push_back(res);
            end
            else
            begin
                qn = an * bd;
                qd = ad * bn;
                if (qd < 0)
                begin
                    qn = -qn;
                    qd = -qd;
                end
                pending_results.push_back(reduce_frac(OP_QUOT, qn, qd, 1'b1));
            end
        end
    endtask

    // One transfer on the input channel; payload is set with valid and held.
    task automatic send_fraction(logic cmd, logic [W-1:0] an, logic [W-2:0] ad,
                                 logic [W-1:0] bn, logic [W-2:0] bd);
        in_valid <= 1'b1;
        command <= cmd;
        a_numerator <= an;
        a_denominator <= ad;
        b_numerator <= bn;
        b_denominator <= bd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_results(cmd, an, ad, bn, bd);
        items_sent++;
    endtask

    task automatic idle_input(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic logic [W-1:0] rand_num();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return '0;
            3: return W'($urandom_range(0, 16)) - W'(8);
            default: return W'($urandom);
        endcase
    endfunction

    function automatic logic [W-2:0] rand_den();
        case ($urandom_range(0, 5))
            0: return 15'h7fff;
            1: return 15'd1;
            2: return 15'd0;
            3: return (W-1)'($urandom_range(1, 24));
            default: return (W-1)'($urandom);
        endcase
    endfunction

    task automatic test_directed();
        send_fraction(1'b0, 16'sd6, 15'd4, 16'sd0, 15'd1);
        send_fraction(1'b0, -16'sd6, 15'd9, 16'sd0, 15'd1);
        send_fraction(1'b0, 16'sd0, 15'd7, 16'sd3, 15'd5);
        send_fraction(1'b0, 16'h8000, 15'h7fff, 16'h7fff, 15'h7fff);
        send_fraction(1'b0, 16'h7fff, 15'd0, 16'h8000, 15'd0);
        send_fraction(1'b1, 16'sd1, 15'd2, 16'sd1, 15'd3);
        send_fraction(1'b1, -16'sd3, 15'd4, 16'sd5, 15'd6);
        send_fraction(1'b1, 16'sd2, 15'd3, -16'sd4, 15'd9);
        send_fraction(1'b1, 16'sd7, 15'd5, 16'sd0, 15'd3);   // zero divisor
        send_fraction(1'b1, 16'sd0, 15'd5, 16'sd0, 15'd3);
        send_fraction(1'b1, 16'h8000, 15'h7fff, 16'h8000, 15'h7fff);
        send_fraction(1'b1, 16'h7fff, 15'h7fff, 16'h8000, 15'd1);
        send_fraction(1'b1, 16'h8000, 15'd1, 16'h7fff, 15'd1);
        send_fraction(1'b1, 16'h7fff, 15'd0, 16'h7fff, 15'd0);
        send_fraction(1'b1, 16'hffff, 15'h5555, 16'h5555, 15'h2aaa);
        drain_results();
    endtask

    task automatic test_random(int n);
        int burst;
        burst = 0;
        for (int i = 0; i < n; i++)
        begin
            if (burst == 0)
            begin
                burst = $urandom_range(1, 8);
                if ($urandom_range(0, 1))
                    idle_input($urandom_range(1, 400));
            end
            send_fraction(1'($urandom_range(0, 1)), rand_num(), rand_den(), rand_num(),
                          rand_den());
            burst--;
        end
    endtask

    // Receiver holds off long; sender keeps offering until the block blocks input.
    task automatic test_backpressure();
        hold_cycles = 6000;
        hold_receiver = 1'b1;
        for (int i = 0; i < 4; i++)
            send_fraction(1'b1, rand_num(), rand_den(), rand_num(), rand_den());
        drain_results();
    endtask

    // Receiver stall pattern: runs of stall/no stall, with quiet stretches.
    initial
    begin
        out_stall = 1'b0;
        hold_receiver = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_receiver)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                hold_receiver = 1'b0;
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0: out_stall <= 1'b0;
                    1: out_stall <= 1'b1;
                    default: out_stall <= ($urandom_range(0, 2) == 0);
                endcase
                repeat ($urandom_range(1, 60)) @(posedge clk);
            end
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        frac_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result op=%0d num=%0d den=%0d",
                             operation, numerator, denominator);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (operation !== exp_res.op || numerator !== exp_res.num
                    || denominator !== exp_res.den || divide_error !== exp_res.derr
                    || last !== exp_res.lst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("ERROR: result %0d exp op=%0d num=%0d den=%0d err=%0b last=%0b",
                                 results_seen, exp_res.op, $signed(exp_res.num),
                                 exp_res.den, exp_res.derr, exp_res.lst);
                        $display("       got op=%0d num=%0d den=%0d err=%0b last=%0b",
                                 operation, numerator, denominator, divide_error, last);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = 1'b0;
        a_numerator = '0;
        a_denominator = '0;
        b_numerator = '0;
        b_denominator = '0;
        mismatches = 0;
        results_seen = 0;
        items_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(190);
        test_backpressure();
        test_random(190);
        drain_results();
        $display("Covered %0d fraction items (reduce and four-way arithmetic), %0d results,",
                 items_sent, results_seen);
        $display("with zero divisors, field extremes, bursty input and output stalls.");
        if (mismatches == 0 && pending_results.size() == 0)
            $display("** fraction_arith_reduce: PASSED **");
        else
            $display("** fraction_arith_reduce: FAILED **");
        $finish;
    end

    initial
    begin
        #2_000_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("** fraction_arith_reduce: FAILED **");
        $finish;
    end
endmodule

/* sim.f */
design/far_pkg.sv
design/far_datapath.sv
design/far_ctrl.sv
design/far_reduce_core.sv
design/fraction_arith_reduce.sv
tb/tb.sv
